### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Whenever the condition holds, the consequent must follow.
`define ASSERT_IMPLY(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("implication check failed");
// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, cond, conseq)
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`endif
`endif

### hdl/rgbhsl_pkg.sv
`timescale 1ns / 1ps
package rgbhsl_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int FRAC_BITS    = 16;
   localparam int HUE_BITS     = 9;
   // Quotient bits per division; one cell per bit.
   localparam int QUO_BITS     = FRAC_BITS + 1;
   // Remainder and shifted divisor width.
   localparam int NUM_BITS     = CHANNEL_BITS + FRAC_BITS + 2;
   // Signed width of the hue numerator before clamping.
   localparam int HNUM_BITS    = CHANNEL_BITS + 11;
   // Accept to result strobe, in clock edges.
   localparam int LATENCY      = QUO_BITS + 2;

   localparam logic [HUE_BITS-1:0] HUE_FULL  = HUE_BITS'(360);
   localparam logic [HUE_BITS-1:0] HUE_RED_N = HUE_BITS'(360);
   localparam logic [HUE_BITS-1:0] HUE_GREEN = HUE_BITS'(120);
   localparam logic [HUE_BITS-1:0] HUE_BLUE  = HUE_BITS'(240);
   localparam logic [HUE_BITS-1:0] HUE_ZERO  = HUE_BITS'(0);
   localparam logic [CHANNEL_BITS-1:0] CHANNEL_MAX_RESET = CHANNEL_BITS'(255);

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_BITS-1:0]  hue;
      logic [FRAC_BITS:0]   saturation;
      logic [FRAC_BITS:0]   lightness;
   } hsl_type;

   // One long division in flight: partial remainder, divisor aligned to
   // the current quotient bit, and the quotient bits found so far.
   typedef struct packed {
      logic [NUM_BITS-1:0] rem;
      logic [NUM_BITS-1:0] den;
      logic [QUO_BITS-1:0] quo;
   } div_type;

   typedef struct packed {
      logic    valid;
      logic    grey;
      div_type lig;
      div_type sat;
      div_type hue;
   } stage_type;

endpackage

### hdl/rgbhsl_front.sv
`timescale 1ns / 1ps
module rgbhsl_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    accept,
   input  rgbhsl_pkg::pixel_type                   pixel,
   input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0]     channel_max,
   output rgbhsl_pkg::stage_type                   stage_out
);
   import rgbhsl_pkg::*;

   logic [CHANNEL_BITS-1:0]          m, r, g, b, mx, mn, d, p, q;
   logic [CHANNEL_BITS:0]            sum, den_s, two_m;
   logic [HUE_BITS-1:0]              base;
   logic [CHANNEL_BITS+HUE_BITS-1:0] prod_b;
   logic signed [CHANNEL_BITS:0]     diff;
   logic signed [CHANNEL_BITS+7:0]   prod_60;
   logic signed [HNUM_BITS-1:0]      t;
   stage_type                        stage_in;
   stage_type                        stage_ff;

   // Clamp the channels and find the extremes.
   always_comb begin
      m   = (channel_max == '0) ? CHANNEL_BITS'(1) : channel_max;
      r   = (pixel.red   > m) ? m : pixel.red;
      g   = (pixel.green > m) ? m : pixel.green;
      b   = (pixel.blue  > m) ? m : pixel.blue;
      mx  = r;
      mn  = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d     = mx - mn;
      sum   = {1'b0, mx} + {1'b0, mn};
      two_m = {m, 1'b0};
      den_s = (sum <= {1'b0, m}) ? sum : (two_m - sum);
   end

   // Hue sector: red wins ties, then green.
   always_comb begin
      if (r == mx) begin
         base = (g >= b) ? HUE_ZERO : HUE_RED_N;
         p    = g;
         q    = b;
      end else if (g == mx) begin
         base = HUE_GREEN;
         p    = b;
         q    = r;
      end else begin
         base = HUE_BLUE;
         p    = r;
         q    = g;
      end
      prod_b  = base * d;
      diff    = $signed({1'b0, p}) - $signed({1'b0, q});
      prod_60 = diff * $signed(8'sd60);
      t       = $signed({2'b00, prod_b}) + HNUM_BITS'(prod_60);
   end

   // Numerators and divisors aligned to the top quotient bit.
   always_comb begin
      stage_in.valid   = accept;
      stage_in.grey    = (d == '0);
      stage_in.lig.rem = NUM_BITS'({sum, {FRAC_BITS{1'b0}}});
      stage_in.lig.den = NUM_BITS'({two_m, {FRAC_BITS{1'b0}}});
      stage_in.lig.quo = '0;
      stage_in.sat.rem = NUM_BITS'({d, {FRAC_BITS{1'b0}}});
      stage_in.sat.den = NUM_BITS'({den_s, {FRAC_BITS{1'b0}}});
      stage_in.sat.quo = '0;
      stage_in.hue.rem = t[HNUM_BITS-1] ? '0 : NUM_BITS'(t[HNUM_BITS-2:0]);
      stage_in.hue.den = NUM_BITS'({d, {FRAC_BITS{1'b0}}});
      stage_in.hue.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.grey <= stage_in.grey;
      stage_ff.lig  <= stage_in.lig;
      stage_ff.sat  <= stage_in.sat;
      stage_ff.hue  <= stage_in.hue;
   end

   assign stage_out = stage_ff;

endmodule

### hdl/rgbhsl_cell.sv
`timescale 1ns / 1ps
module rgbhsl_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  rgbhsl_pkg::stage_type stage_prev,
   output rgbhsl_pkg::stage_type stage_next
);
   import rgbhsl_pkg::*;

   stage_type stage_in;
   stage_type stage_ff;

   // One restoring step: subtract the aligned divisor if it fits.
   function automatic div_type div_step(input div_type x);
      div_type y;
      logic    fit;
      fit   = (x.rem >= x.den);
      y.rem = fit ? (x.rem - x.den) : x.rem;
      y.den = x.den >> 1;
      y.quo = {x.quo[QUO_BITS-2:0], fit};
      return y;
   endfunction

   always_comb begin
      stage_in.valid = stage_prev.valid;
      stage_in.grey  = stage_prev.grey;
      stage_in.lig   = div_step(stage_prev.lig);
      stage_in.sat   = div_step(stage_prev.sat);
      stage_in.hue   = div_step(stage_prev.hue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff.grey <= stage_in.grey;
      stage_ff.lig  <= stage_in.lig;
      stage_ff.sat  <= stage_in.sat;
      stage_ff.hue  <= stage_in.hue;
   end

   assign stage_next = stage_ff;

endmodule

### hdl/rgb_to_hsl.sv
`timescale 1ns / 1ps
// RGB to HSL converter. One pixel item is taken in every clock cycle that
// start is high (busy is always low), and its result appears on the rsp_
// ports with rsp_valid high for exactly one cycle, after passing through
// one register of clamping and sector selection loaded at the accept edge,
// one cell per quotient bit in a chain of 17 long-division cells, and one
// output register. The receiver cannot stall the block, so results must be
// taken when shown. The user must write channel_max through the csr_ port
// only while no item is in flight; the block itself does not enforce this.
`include "assert_macros.svh"
module rgb_to_hsl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rgbhsl_pkg::pixel_type               req_pixel,
   output logic                                rsp_valid,
   output rgbhsl_pkg::hsl_type                 rsp_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] csr_data
);
   import rgbhsl_pkg::*;

   logic [CHANNEL_BITS-1:0] channel_max_ff;
   logic                    accept;
   stage_type               chain [0:QUO_BITS];
   logic [HUE_BITS-1:0]     hue_raw;
   logic                    rsp_valid_in;
   logic                    rsp_valid_ff;
   hsl_type                 rsp_in;
   hsl_type                 rsp_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // Full-scale register.
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_max_ff <= CHANNEL_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         channel_max_ff <= csr_data;
      end
   end

   rgbhsl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_pixel),
      .channel_max (channel_max_ff),
      .stage_out   (chain[0])
   );

   // One division cell per quotient bit.
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      rgbhsl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .stage_prev (chain[i]),
         .stage_next (chain[i+1])
      );
   end

   // Wrap the hue and blank hue and saturation for grey pixels.
   always_comb begin
      hue_raw           = chain[QUO_BITS].hue.quo[HUE_BITS-1:0];
      rsp_valid_in      = chain[QUO_BITS].valid;
      rsp_in.hue        = (hue_raw >= HUE_FULL) ? (hue_raw - HUE_FULL) : hue_raw;
      rsp_in.saturation = chain[QUO_BITS].sat.quo;
      rsp_in.lightness  = chain[QUO_BITS].lig.quo;
      if (chain[QUO_BITS].grey) begin
         rsp_in.hue        = '0;
         rsp_in.saturation = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   `ASSERT_IMPLY(a_latency, clock, reset, accept, ##LATENCY rsp_valid)
   `ASSERT_IMPLY(a_hue_range, clock, reset, rsp_valid, rsp_result.hue < HUE_FULL)
   `ASSERT_IMPLY(a_sat_range, clock, reset, rsp_valid, rsp_result.saturation <= (1 << FRAC_BITS))
   `ASSERT_IMPLY(a_lig_range, clock, reset, rsp_valid, rsp_result.lightness <= (1 << FRAC_BITS))

endmodule

### tb/hsl_checker.sv
`timescale 1ns / 1ps
module hsl_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  rgbhsl_pkg::pixel_type               req_pixel,
   input  logic                                rsp_valid,
   input  rgbhsl_pkg::hsl_type                 rsp_result,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] csr_data,
   output int                                  error_count,
   output int                                  pending_count
);
   import rgbhsl_pkg::*;

   logic [CHANNEL_BITS-1:0] full_scale;
   hsl_type pending_hsl[$];

   // Floor of the sector angle, never below zero.
   function automatic longint sector_angle(longint base, longint p, longint q, longint d);
      longint t;
      t = base * d + 60 * (p - q);
      if (t < 0) t = 0;
      return t / d;
   endfunction

   // Exact HSL of one pixel under the current full scale.
   function automatic hsl_type convert_pixel(pixel_type px, logic [CHANNEL_BITS-1:0] fs);
      longint m, r, g, b, mx, mn, d, sum, den, hue, sat, lig;
      hsl_type res;
      m = (fs == 0) ? 1 : fs;
      r = (px.red > m) ? m : px.red;
      g = (px.green > m) ? m : px.green;
      b = (px.blue > m) ? m : px.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      sum = mx + mn;
      lig = (sum << FRAC_BITS) / (2 * m);
      hue = 0;
      sat = 0;
      if (d != 0) begin
         den = (sum <= m) ? sum : (2 * m - sum);
         sat = (d << FRAC_BITS) / den;
         if (r == mx) hue = sector_angle((g >= b) ? 0 : 360, g, b, d);
         else if (g == mx) hue = sector_angle(120, b, r, d);
         else hue = sector_angle(240, r, g, d);
         if (hue >= 360) hue -= 360;
      end
      res.hue = hue[HUE_BITS-1:0];
      res.saturation = sat[FRAC_BITS:0];
      res.lightness = lig[FRAC_BITS:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   assign pending_count = pending_hsl.size();

   always @(posedge clock) begin
      hsl_type want;
      if (reset) begin
         full_scale <= CHANNEL_MAX_RESET;
         pending_hsl.delete();
         error_count = 0;
      end else begin
         // Results leave before new items join, so an item accepted now is never compared now.
         if (rsp_valid) begin
            if (pending_hsl.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = pending_hsl.pop_front();
               if (rsp_result.hue !== want.hue)
                  report_mismatch("hue", rsp_result.hue, want.hue);
               if (rsp_result.saturation !== want.saturation)
                  report_mismatch("saturation", rsp_result.saturation, want.saturation);
               if (rsp_result.lightness !== want.lightness)
                  report_mismatch("lightness", rsp_result.lightness, want.lightness);
            end
         end
         if (start && !busy) pending_hsl.push_back(convert_pixel(req_pixel, full_scale));
         if (csr_valid && csr_ready) full_scale <= csr_data;
      end
   end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import rgbhsl_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pixel_type req_pixel = '0;
   logic rsp_valid;
   hsl_type rsp_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CHANNEL_BITS-1:0] csr_data = '0;
   int error_count;
   int pending_count;
   int idle_pct;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rgb_to_hsl uut (.*);

   hsl_checker checker_inst (.*);

   // Offer one pixel, idling at random first; return once it is taken.
   task automatic send_pixel(pixel_type px);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drain all results, let the pipeline settle, then write the full scale.
   task automatic set_full_scale(logic [CHANNEL_BITS-1:0] fs);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= fs;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CHANNEL_BITS-1:0] rand_chan();
      return CHANNEL_BITS'($urandom_range(255));
   endfunction

   // Random channel no larger than the given full scale.
   function automatic logic [CHANNEL_BITS-1:0] rand_below(logic [CHANNEL_BITS-1:0] fs);
      return CHANNEL_BITS'($urandom_range(fs));
   endfunction

   initial begin
      #400000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [CHANNEL_BITS-1:0] scales[6];
      pixel_type px;
      int mode;
      scales = '{8'd255, 8'd1, 8'd0, 8'd128, 8'd200, 8'd37};
      idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, greys, ties, each sector and the red wrap.
      send_pixel('{8'd0, 8'd0, 8'd0});
      send_pixel('{8'd255, 8'd255, 8'd255});
      send_pixel('{8'd128, 8'd128, 8'd128});
      send_pixel('{8'd255, 8'd0, 8'd0});
      send_pixel('{8'd0, 8'd255, 8'd0});
      send_pixel('{8'd0, 8'd0, 8'd255});
      send_pixel('{8'd255, 8'd255, 8'd0});
      send_pixel('{8'd0, 8'd255, 8'd255});
      send_pixel('{8'd255, 8'd0, 8'd255});
      send_pixel('{8'd255, 8'd0, 8'd1});
      send_pixel('{8'd200, 8'd10, 8'd100});
      send_pixel('{8'd30, 8'd200, 8'd90});
      send_pixel('{8'd1, 8'd0, 8'd0});
      send_pixel('{8'd254, 8'd255, 8'd255});
      send_pixel('{8'd170, 8'd85, 8'd0});
      set_full_scale(8'd100);
      // Channels above full scale are clamped.
      send_pixel('{8'd255, 8'd150, 8'd20});
      send_pixel('{8'd101, 8'd100, 8'd0});
      send_pixel('{8'd255, 8'd255, 8'd255});
      set_full_scale(8'd0);
      // A zero full scale behaves as one.
      send_pixel('{8'd1, 8'd0, 8'd0});
      send_pixel('{8'd0, 8'd200, 8'd0});
      send_pixel('{8'd0, 8'd0, 8'd0});

      // Random phases across full scales and idling levels.
      for (int phase = 0; phase < 12; phase++) begin
         set_full_scale(scales[phase % 6]);
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 75;
            2: idle_pct = 15;
            default: idle_pct = 0;
         endcase
         repeat (135) begin
            mode = $urandom_range(9);
            px = '{rand_chan(), rand_chan(), rand_chan()};
            // Some items within full scale, some grey, some with ties.
            if (mode == 0) px.green = px.red;
            else if (mode == 1) px = '{px.red, px.red, px.red};
            else if (mode == 2) px.blue = px.red;
            else if (mode < 6 && scales[phase % 6] > 1)
               px = '{rand_below(scales[phase % 6]), rand_below(scales[phase % 6]),
                      rand_below(scales[phase % 6])};
            send_pixel(px);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+hdl
hdl/rgbhsl_pkg.sv
hdl/rgbhsl_front.sv
hdl/rgbhsl_cell.sv
hdl/rgb_to_hsl.sv
tb/hsl_checker.sv
tb/testbench.sv
